/* src/md5bmf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// md5bmf_pkg
// Types, constants and round functions shared by the md5 block match filter.
// ----------------------------------------------------------------------------
package md5bmf_pkg;

	localparam int NUM_ROUNDS     = 64;
	localparam int OUTQ_DEPTH_DEF = 4;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	// configuration register indexes
	localparam logic REG_SEARCH_LOW  = 1'b0;
	localparam logic REG_SEARCH_HIGH = 1'b1;

	typedef struct packed {
		logic [63:0] block_w0;
		logic [63:0] block_w1;
		logic [63:0] block_w2;
		logic [63:0] block_w3;
		logic [63:0] block_w4;
		logic [63:0] block_w5;
		logic [63:0] block_w6;
		logic [63:0] block_w7;
		logic [63:0] byte_keep;
		logic        end_of_stream;
	} blk_t;

	typedef struct packed {
		logic [63:0] data_0;
		logic [63:0] data_1;
		logic [63:0] data_2;
		logic [63:0] data_3;
		logic [63:0] data_4;
		logic [63:0] data_5;
		logic [63:0] data_6;
		logic [63:0] data_7;
		logic [63:0] out_keep;
		logic        out_last;
	} res_t;

	// working state handed from one round cell to the next
	typedef struct packed {
		logic         last;
		logic [63:0]  keep;
		logic [31:0]  a;
		logic [31:0]  b;
		logic [31:0]  c;
		logic [31:0]  d;
		logic [511:0] blk;
	} md5_st_t;

	// results produced by one finished block, at most two
	typedef struct packed {
		logic one;
		logic two;
		res_t r0;
		res_t r1;
	} push_t;

	function automatic res_t mk_res(input logic [511:0] blk, input logic [63:0] keep,
			input logic last);
		res_t r;
		r.data_0   = blk[63:0];
		r.data_1   = blk[127:64];
		r.data_2   = blk[191:128];
		r.data_3   = blk[255:192];
		r.data_4   = blk[319:256];
		r.data_5   = blk[383:320];
		r.data_6   = blk[447:384];
		r.data_7   = blk[511:448];
		r.out_keep = keep;
		r.out_last = last;
		return r;
	endfunction

	function automatic logic [31:0] md5_k(input logic [5:0] i);
		logic [31:0] k;
		unique case (i)
			6'd0:  k = 32'hd76aa478;
			6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db;
			6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf;
			6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613;
			6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8;
			6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;
			6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;
			6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;
			6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;
			6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;
			6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;
			6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;
			6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;
			6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;
			6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;
			6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;
			6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;
			6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;
			6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;
			6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;
			6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;
			6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;
			6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;
			6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;
			default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] md5_s(input logic [5:0] i);
		logic [4:0] s;
		unique case ({i[5:4], i[1:0]})
			4'd0:  s = 5'd7;
			4'd1:  s = 5'd12;
			4'd2:  s = 5'd17;
			4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;
			4'd5:  s = 5'd9;
			4'd6:  s = 5'd14;
			4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;
			4'd9:  s = 5'd11;
			4'd10: s = 5'd16;
			4'd11: s = 5'd23;
			4'd12: s = 5'd6;
			4'd13: s = 5'd10;
			4'd14: s = 5'd15;
			default: s = 5'd21;
		endcase
		return s;
	endfunction

	// message word index, taken mod 16
	function automatic logic [3:0] md5_g(input logic [5:0] i);
		logic [3:0] j;
		logic [3:0] g;
		j = i[3:0];
		unique case (i[5:4])
			2'd0:    g = j;
			2'd1:    g = 4'(j * 4'd5 + 4'd1);
			2'd2:    g = 4'(j * 4'd3 + 4'd5);
			default: g = 4'(j * 4'd7);
		endcase
		return g;
	endfunction

	function automatic logic [31:0] md5_f(input logic [1:0] rnd, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		unique case (rnd)
			2'd0:    f = (b & c) | (~b & d);
			2'd1:    f = (d & b) | (~d & c);
			2'd2:    f = b ^ c ^ d;
			default: f = c ^ (b | ~d);
		endcase
		return f;
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
		return (x << s) | (x >> (6'd32 - {1'b0, s}));
	endfunction

endpackage
`default_nettype wire

/* src/md5bmf_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// md5bmf_cell
// One md5 round: mixes the working words and hands them to the next cell.
// ----------------------------------------------------------------------------
module md5bmf_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic [5:0]         round_idx,
	input  wire logic               vld_in,
	input  wire md5bmf_pkg::md5_st_t st_in,
	output logic                    vld_out,
	output md5bmf_pkg::md5_st_t     st_out
);
	import md5bmf_pkg::*;

	logic [3:0]  g;
	logic [31:0] f;
	logic [31:0] sum;
	md5_st_t     nxt;
	logic        vld_q;
	md5_st_t     st_q;

	always_comb begin
		g        = md5_g(round_idx);
		f        = md5_f(round_idx[5:4], st_in.b, st_in.c, st_in.d);
		sum      = f + st_in.a + md5_k(round_idx) + st_in.blk[32 * g +: 32];
		nxt      = st_in;
		nxt.a    = st_in.d;
		nxt.d    = st_in.c;
		nxt.c    = st_in.b;
		nxt.b    = st_in.b + rotl32(sum, md5_s(round_idx));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q <= nxt;
		end
	end

	assign vld_out = vld_q;
	assign st_out  = st_q;

endmodule
`default_nettype wire

/* src/md5bmf_filter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// md5bmf_filter
// Final digest add, compare with the search hash and hold of the last match.
// ----------------------------------------------------------------------------
module md5bmf_filter (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                take,
	input  wire md5bmf_pkg::md5_st_t st,
	input  wire logic [63:0]         search_lo,
	input  wire logic [63:0]         search_hi,
	output md5bmf_pkg::push_t        push
);
	import md5bmf_pkg::*;

	logic         held_valid_q;
	logic [511:0] held_blk_q;
	logic [63:0]  held_keep_q;

	logic [31:0] a_f, b_f, c_f, d_f;
	logic        match;
	logic        displace;
	res_t        final_r;
	res_t        held_r;

	always_comb begin
		a_f      = IV_A + st.a;
		b_f      = IV_B + st.b;
		c_f      = IV_C + st.c;
		d_f      = IV_D + st.d;
		match    = ({b_f, a_f} == search_lo) && ({d_f, c_f} == search_hi);
		displace = match && held_valid_q;
		held_r   = mk_res(held_blk_q, held_keep_q, 1'b0);
		priority if (match) begin
			final_r = mk_res(st.blk, st.keep, 1'b1);
		end else if (held_valid_q) begin
			final_r = mk_res(held_blk_q, held_keep_q, 1'b1);
		end else begin
			// empty stream result
			final_r = mk_res('0, 64'd1, 1'b1);
		end
		push.one = take && (displace || st.last);
		push.two = take && displace && st.last;
		push.r0  = displace ? held_r : final_r;
		push.r1  = final_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
		end else if (take) begin
			held_valid_q <= !st.last && (held_valid_q || match);
		end
	end

	always_ff @(posedge clk) begin
		if (take && match) begin
			held_blk_q  <= st.blk;
			held_keep_q <= st.keep;
		end
	end

endmodule
`default_nettype wire

/* src/md5bmf_outq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// md5bmf_outq
// Result queue: takes up to two results a cycle, gives one a cycle.
// ----------------------------------------------------------------------------
module md5bmf_outq #(
	parameter int DEPTH = md5bmf_pkg::OUTQ_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire md5bmf_pkg::push_t push,
	input  wire logic              pop,
	output md5bmf_pkg::res_t       head,
	output logic                   not_empty,
	output logic                   room2,
	output logic [$clog2(DEPTH+1)-1:0] fill
);
	import md5bmf_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	res_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] wr_p1;
	logic [PTR_W-1:0] wr_p2;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_p1 = ptr_inc(wr_q);
	assign wr_p2 = ptr_inc(wr_p1);

	always_ff @(posedge clk) begin
		if (push.one) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.two) begin
			mem_q[wr_p1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.two) begin
				wr_q <= wr_p2;
			end else if (push.one) begin
				wr_q <= wr_p1;
			end
			if (pop) begin
				rd_q <= ptr_inc(rd_q);
			end
			cnt_q <= cnt_q + CNT_W'(push.one) + CNT_W'(push.two) - CNT_W'(pop);
		end
	end

	assign head      = mem_q[rd_q];
	assign not_empty = (cnt_q != '0);
	assign room2     = (cnt_q <= CNT_W'(DEPTH - 2));
	assign fill      = cnt_q;

endmodule
`default_nettype wire

/* src/md5_block_match_filter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// md5_block_match_filter
// Hashes padded 512-bit blocks and passes on the blocks matching a search hash.
// ----------------------------------------------------------------------------
// Takes one block per clock while blk_stall is low. Each block runs through a
// chain of 64 md5 round cells, one round per cell, then a combinational digest
// add and compare at the end of the chain. Matching blocks are held back: a
// newer match releases the one before it, and the end of the stream releases
// the held one with out_last set (or a zero block with keep 1 if nothing
// matched). Results go through a small queue of OUTQ_DEPTH entries; the whole
// chain halts while a finished block waits and the queue has fewer than two
// free entries, so blk_stall follows the queue fill. search_low and search_high
// are compared against words {b,a} and {d,c} of the digest.
// ----------------------------------------------------------------------------
module md5_block_match_filter #(
	parameter int OUTQ_DEPTH = md5bmf_pkg::OUTQ_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             blk_valid,
	output logic                  blk_stall,
	input  wire md5bmf_pkg::blk_t blk_data,
	output logic                  res_valid,
	input  wire logic             res_stall,
	output md5bmf_pkg::res_t      res_data,
	input  wire logic             cfg_we,
	input  wire logic             cfg_idx,
	input  wire logic [63:0]      cfg_wdata
);
	import md5bmf_pkg::*;

	localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

	logic [63:0] search_lo_q;
	logic [63:0] search_hi_q;

	md5_st_t    st_chain  [NUM_ROUNDS + 1];
	logic       vld_chain [NUM_ROUNDS + 1];
	logic       chain_adv;
	logic       room2;
	logic       take;
	push_t      push;
	logic [CNT_W-1:0] fill;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_lo_q <= '0;
			search_hi_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SEARCH_LOW:  search_lo_q <= cfg_wdata;
				REG_SEARCH_HIGH: search_hi_q <= cfg_wdata;
				default:         search_lo_q <= search_lo_q;
			endcase
		end
	end

	// the whole chain moves together unless a finished block has nowhere to go
	assign chain_adv = !vld_chain[NUM_ROUNDS] || room2;
	assign blk_stall = !chain_adv;
	assign take      = vld_chain[NUM_ROUNDS] && chain_adv;

	always_comb begin
		vld_chain[0]     = blk_valid;
		st_chain[0].last = blk_data.end_of_stream;
		st_chain[0].keep = blk_data.byte_keep;
		st_chain[0].a    = IV_A;
		st_chain[0].b    = IV_B;
		st_chain[0].c    = IV_C;
		st_chain[0].d    = IV_D;
		st_chain[0].blk  = {blk_data.block_w7, blk_data.block_w6, blk_data.block_w5,
			blk_data.block_w4, blk_data.block_w3, blk_data.block_w2,
			blk_data.block_w1, blk_data.block_w0};
	end

	for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
		md5bmf_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (chain_adv),
			.round_idx (6'(r)),
			.vld_in    (vld_chain[r]),
			.st_in     (st_chain[r]),
			.vld_out   (vld_chain[r + 1]),
			.st_out    (st_chain[r + 1])
		);
	end

	md5bmf_filter u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.st        (st_chain[NUM_ROUNDS]),
		.search_lo (search_lo_q),
		.search_hi (search_hi_q),
		.push      (push)
	);

	md5bmf_outq #(
		.DEPTH (OUTQ_DEPTH)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (res_valid && !res_stall),
		.head      (res_data),
		.not_empty (res_valid),
		.room2     (room2),
		.fill      (fill)
	);

	a_two_needs_one: assert property (@(posedge clk) disable iff (!arst_n)
		push.two |-> push.one)
		else $error("second result pushed without a first");

	a_stream_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		(take && st_chain[NUM_ROUNDS].last) |-> push.one)
		else $error("stream end produced no result");

	a_no_push_on_halt: assert property (@(posedge clk) disable iff (!arst_n)
		!chain_adv |-> !push.one)
		else $error("result pushed while chain halted");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= CNT_W'(OUTQ_DEPTH))
		else $error("result queue overflow");

endmodule
`default_nettype wire
